// File: design/ffrp_pkg.sv
// Shared types, constants and codes for the first-fit rectangle packer.
`timescale 1ns / 1ps

package ffrp_pkg;

    localparam int MAX_FREE_RECTS = 64;
    localparam int MAX_DIM        = 16384;
    localparam int IDX_W          = $clog2(MAX_FREE_RECTS);
    localparam int CNT_W          = $clog2(MAX_FREE_RECTS + 1);
    localparam int POS_W          = 14;
    localparam int DIM_W          = 15;
    localparam int CFG_IDX_W      = 1;

    localparam logic [DIM_W-1:0] DIM_CLAMP   = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] ATLAS_RESET = DIM_W'(1024);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'b1;

    typedef struct packed {
        logic             func;
        logic [DIM_W-1:0] req_width;
        logic [DIM_W-1:0] req_height;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [DIM_W-1:0] placed_width;
        logic [DIM_W-1:0] placed_height;
    } t_out;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_entry;

    typedef struct packed {
        logic       take;
        logic       scan;
        logic       sel_load;
        logic       rd_last;
        logic       wr_clear;
        logic       wr_move;
        logic       wr_right;
        logic       wr_bottom;
        logic       wr_corner;
        logic       res_load;
        logic [1:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic             is_clear;
        logic             zero_req;
        logic             empty;
        logic             hit;
        logic             scan_end;
        logic             full;
        logic             has_right;
        logic             has_bottom;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_sts;

endpackage

// File: design/ffrp_ctrl.sv
// Sequencing state machine of the first-fit rectangle packer.
`timescale 1ns / 1ps

module ffrp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ffrp_pkg::t_sts i_sts,
    output ffrp_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import ffrp_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_LAST     = 4'd3;
    localparam logic [3:0] S_MOVE     = 4'd4;
    localparam logic [3:0] S_RIGHT    = 4'd5;
    localparam logic [3:0] S_BOTTOM   = 4'd6;
    localparam logic [3:0] S_CORNER   = 4'd7;
    localparam logic [3:0] S_CLEAR    = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_clear) begin
                    n_state = S_CLEAR;
                end else if (i_sts.zero_req) begin
                    n_status = ST_ZERO;
                    n_state  = S_DONE;
                end else if (i_sts.empty) begin
                    n_status = ST_NOFIT;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.sel_load = 1'b1;
                    n_state        = S_LAST;
                end else if (i_sts.scan_end) begin
                    n_status = ST_NOFIT;
                    n_state  = S_DONE;
                end
            end
            S_LAST: begin
                // fetch the tail entry while the overflow check settles
                o_cmd.rd_last = 1'b1;
                if (i_sts.full) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.wr_move = 1'b1;
                n_state       = S_RIGHT;
            end
            S_RIGHT: begin
                o_cmd.wr_right = i_sts.has_right;
                n_state        = S_BOTTOM;
            end
            S_BOTTOM: begin
                o_cmd.wr_bottom = i_sts.has_bottom;
                n_state         = S_CORNER;
            end
            S_CORNER: begin
                o_cmd.wr_corner = i_sts.has_right & i_sts.has_bottom;
                n_status        = ST_OK;
                n_state         = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.wr_clear = 1'b1;
                n_status       = ST_OK;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the transaction
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.res_status = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: design/ffrp_dp.sv
// Datapath of the first-fit rectangle packer: free list memory, scan and result.
`timescale 1ns / 1ps

module ffrp_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ffrp_pkg::t_in                      i_in,
    input  logic                               i_stall,
    input  logic                               i_cfg_we,
    input  logic [ffrp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ffrp_pkg::DIM_W-1:0]         i_cfg_data,
    input  ffrp_pkg::t_cmd                     i_cmd,
    output ffrp_pkg::t_sts                     o_sts,
    output logic                               o_valid,
    output ffrp_pkg::t_out                     o_out
);
    import ffrp_pkg::*;

    t_entry mem [MAX_FREE_RECTS];

    logic [DIM_W-1:0] r_atlas_w, r_atlas_h;
    t_in              r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_scan_idx;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_found;
    t_entry           r_sel;
    t_entry           r_rd_data;
    logic             r_out_valid;
    t_out             r_out;

    logic             fits;
    logic [CNT_W-1:0] count_m1;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    t_entry           clear_ent, right_ent, bottom_ent, corner_ent;
    logic [POS_W-1:0] x_adv, y_adv;
    logic [DIM_W-1:0] w_rem, h_rem;
    logic             has_right, has_bottom;
    logic [CNT_W:0]   grown;

    assign fits     = (r_req.req_width <= r_rd_data.w) && (r_req.req_height <= r_rd_data.h);
    assign count_m1 = r_count - 1'b1;

    assign has_right  = r_req.req_width < r_sel.w;
    assign has_bottom = r_req.req_height < r_sel.h;
    assign x_adv = POS_W'(r_sel.x + r_req.req_width);
    assign y_adv = POS_W'(r_sel.y + r_req.req_height);
    assign w_rem = r_sel.w - r_req.req_width;
    assign h_rem = r_sel.h - r_req.req_height;

    // count after removing one entry and appending the pieces, plus one
    assign grown = {1'b0, r_count} + (CNT_W + 1)'(has_right) + (CNT_W + 1)'(has_bottom)
                 + (CNT_W + 1)'(has_right & has_bottom);

    always_comb begin
        clear_ent.x = '0;
        clear_ent.y = '0;
        clear_ent.w = (r_atlas_w > DIM_CLAMP) ? DIM_CLAMP : r_atlas_w;
        clear_ent.h = (r_atlas_h > DIM_CLAMP) ? DIM_CLAMP : r_atlas_h;
        right_ent   = '{x: x_adv, y: r_sel.y, w: w_rem, h: r_req.req_height};
        bottom_ent  = '{x: r_sel.x, y: y_adv, w: r_req.req_width, h: h_rem};
        corner_ent  = '{x: x_adv, y: y_adv, w: w_rem, h: h_rem};
    end

    always_comb begin
        wr_en   = i_cmd.wr_clear | i_cmd.wr_move | i_cmd.wr_right
                | i_cmd.wr_bottom | i_cmd.wr_corner;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = corner_ent;
        if (i_cmd.wr_clear) begin
            wr_addr = '0;
            wr_data = clear_ent;
        end else if (i_cmd.wr_move) begin
            wr_addr = r_found;
            wr_data = r_rd_data;
        end else if (i_cmd.wr_right) begin
            wr_data = right_ent;
        end else if (i_cmd.wr_bottom) begin
            wr_data = bottom_ent;
        end
    end

    assign rd_addr = i_cmd.rd_last ? count_m1[IDX_W-1:0] : r_scan_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w   <= ATLAS_RESET;
            r_atlas_h   <= ATLAS_RESET;
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ATLAS_WIDTH:  r_atlas_w <= i_cfg_data;
                    CFG_ATLAS_HEIGHT: r_atlas_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
            end else if (i_cmd.scan) begin
                // stop advancing at the fill level, the compare stage drains
                if (r_scan_idx < r_count) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                r_cmp_vld <= r_scan_idx < r_count;
            end
            if (i_cmd.wr_clear) begin
                r_count <= CNT_W'(1);
            end else if (i_cmd.wr_move) begin
                r_count <= count_m1;
            end else if (i_cmd.wr_right | i_cmd.wr_bottom | i_cmd.wr_corner) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req <= i_in;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_scan_idx[IDX_W-1:0];
        end
        if (i_cmd.sel_load) begin
            r_sel   <= r_rd_data;
            r_found <= r_cmp_idx;
        end
        if (i_cmd.res_load) begin
            r_out.status <= i_cmd.res_status;
            if (i_cmd.res_status == ST_OK && r_req.func == FUNC_ALLOC) begin
                r_out.pos_x         <= r_sel.x;
                r_out.pos_y         <= r_sel.y;
                r_out.placed_width  <= r_req.req_width;
                r_out.placed_height <= r_req.req_height;
            end else begin
                r_out.pos_x         <= '0;
                r_out.pos_y         <= '0;
                r_out.placed_width  <= '0;
                r_out.placed_height <= '0;
            end
        end
    end

    always_comb begin
        o_sts.is_clear   = (r_req.func == FUNC_CLEAR);
        o_sts.zero_req   = (r_req.req_width == '0) || (r_req.req_height == '0);
        o_sts.empty      = (r_count == '0);
        o_sts.hit        = r_cmp_vld && fits;
        o_sts.scan_end   = r_cmp_vld && !fits && ({1'b0, r_cmp_idx} == count_m1);
        o_sts.full       = grown > (CNT_W + 1)'(MAX_FREE_RECTS + 1);
        o_sts.has_right  = has_right;
        o_sts.has_bottom = has_bottom;
        o_sts.out_free   = !r_out_valid || !i_stall;
        o_sts.count      = r_count;
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// File: design/first_fit_rect_packer_top.sv
// Top level of the first-fit rectangle packer.
`timescale 1ns / 1ps

// Atlas allocator with a free list of up to 64 rectangles held in a one-read,
// one-write memory. One transaction is worked on at a time. A clear resets
// the list to one entry covering the atlas. An allocate that places runs the
// first-fit scan up to the fitting entry, then removes that entry and appends
// the pieces. An allocate that fits nowhere scans the whole list, and one
// that would overflow the list reports full after its scan. The scan reads
// one entry per cycle through the memory read port. Rejected requests (zero
// size, empty list) finish without a scan. The result sits in an output
// register, so the next transaction is accepted while it waits. The list
// needs no clearing pass after reset; allocate before any clear reports no
// fit.
module first_fit_rect_packer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  ffrp_pkg::t_in                   i_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output ffrp_pkg::t_out                  o_out,
    input  logic                            i_cfg_we,
    input  logic [ffrp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffrp_pkg::DIM_W-1:0]      i_cfg_data
);
    import ffrp_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;

    ffrp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ffrp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .o_out      (o_out)
    );

    assign o_stall = busy;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.count <= CNT_W'(MAX_FREE_RECTS))
        else $error("free list count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("accepted transaction did not occupy the block");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status != ST_OK) |->
        (o_out.pos_x == '0 && o_out.pos_y == '0 &&
         o_out.placed_width == '0 && o_out.placed_height == '0))
        else $error("rejected result carries a placement");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> sts.out_free)
        else $error("result loaded over one still waiting");

endmodule
